/* design/rria_pkg.sv */
package rria_pkg;

   // Identifier and count fields are nine bits wide.
   localparam int ID_W = 9;
   // The used map is held as 32-bit memory words.
   localparam int WORD_W = 32;
   localparam int BIT_W = 5;
   // Bits of an identifier that select its memory word.
   localparam int WN_W = ID_W - BIT_W;

   localparam int MAX_IDS_DEFAULT = 256;
   localparam logic [ID_W-1:0] MAX_INDEX_RESET = 9'd256;

   // Request kinds carried on req_type.
   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // Byte address of the max_index register.
   localparam logic [1:0] MAX_INDEX_ADDR = 2'd0;

   // Which part of a memory word a scan read covers.
   typedef enum logic [1:0] {
      PH_FIRST,
      PH_MID,
      PH_FINAL
   } phase_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } pick_type;

   // Next identifier after id, wrapping from m back to 1.
   function automatic logic [ID_W-1:0] advance(input logic [ID_W-1:0] id,
                                               input logic [ID_W-1:0] m);
      if (id >= m) begin
         advance = ID_W'(1);
      end else begin
         advance = id + ID_W'(1);
      end
   endfunction

endpackage

/* design/round_robin_id_allocator_core.sv */
// Round robin identifier allocator.
// Request channel (req_valid, req_stall, req_type, req_release_id): a beat
// with req_type 0 allocates the next free identifier at or after the cursor,
// wrapping from the maximum back to 1; req_type 1 releases req_release_id.
// Result channel (rsp_valid, rsp_stall): exactly one beat per request, with
// the granted identifier (0 when none is free or for a release) and the
// count of identifiers in use after the request.
// The used map sits in a single-port-read memory of 32-bit words, one bit
// per identifier. An allocation reads one word a cycle from the cursor's
// word onwards and picks the lowest free bit; the search ends at the first
// hit or after revisiting the starting word. A release reads one word.
// Requests are handled one at a time; req_stall is high while one is open.
// A finished result is held in the output register, so a new request is
// taken while a result waits; a result that is still stalled holds the
// next one back. Reset clears a valid flag per memory word, so the map reads
// as empty at once with no clearing pass; the cursor returns to 1, the count
// to 0 and max_index to 256. max_index is written over the csr_ port.
module round_robin_id_allocator_core #(
   parameter int MAX_IDS = rria_pkg::MAX_IDS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic [rria_pkg::ID_W-1:0] req_release_id,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [rria_pkg::ID_W-1:0] rsp_granted_id,
   output logic [rria_pkg::ID_W-1:0] rsp_used_count,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [1:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int ID_W = rria_pkg::ID_W;
   localparam int WORD_W = rria_pkg::WORD_W;
   localparam int BIT_W = rria_pkg::BIT_W;
   localparam int WN_W = rria_pkg::WN_W;
   // The fields cannot name an identifier above this.
   localparam int ID_LIMIT = (MAX_IDS > (1 << ID_W) - 1) ? (1 << ID_W) - 1 : MAX_IDS;
   localparam int WORDS = ID_LIMIT / WORD_W + 1;
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REL,
      ST_FIN
   } state_type;

   state_type           state_ff, state_in;
   logic [ID_W-1:0]     max_index_ff, max_index_in;
   logic [ID_W-1:0]     cursor_ff, cursor_in;
   logic [ID_W-1:0]     count_ff, count_in;
   logic [WORDS-1:0]    row_valid_ff, row_valid_in;
   logic [ID_W-1:0]     m_ff, m_in;
   logic [ID_W-1:0]     start_ff, start_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic                issue_on_ff, issue_on_in;
   logic [AW-1:0]       issue_word_ff, issue_word_in;
   rria_pkg::phase_type issue_phase_ff, issue_phase_in;
   logic                ev_valid_ff, ev_valid_in;
   logic [AW-1:0]       ev_word_ff, ev_word_in;
   rria_pkg::phase_type ev_phase_ff, ev_phase_in;
   logic                pend_wr_ff, pend_wr_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in;
   logic [WORD_W-1:0]   pend_data_ff, pend_data_in;
   logic [ID_W-1:0]     pend_grant_ff, pend_grant_in;
   logic [ID_W-1:0]     pend_count_ff, pend_count_in;
   logic [ID_W-1:0]     pend_cursor_ff, pend_cursor_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_grant_ff, rsp_grant_in;
   logic [ID_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                ram_rd_en, ram_wr_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [WORD_W-1:0]   ram_rd_data;
   logic [WORD_W-1:0]   scan_data;
   rria_pkg::pick_type  pick;

   logic                req_accept, csr_write, out_free;
   logic [ID_W-1:0]     eff_max, req_start;
   logic [AW-1:0]       start_word, last_word, next_word, rel_word;
   logic                req_rel_ok, rel_ok, rel_hit;
   logic [ID_W-1:0]     found_id;
   logic [WORD_W-1:0]   found_bit, rel_bit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == rria_pkg::MAX_INDEX_ADDR) ? 32'(max_index_ff) : 32'd0;

   // Effective maximum: a value of 0 acts as 1, and nothing beyond the
   // configured capacity is handed out.
   always_comb begin
      if (max_index_ff == '0) begin
         eff_max = ID_W'(1);
      end else if (max_index_ff > ID_W'(ID_LIMIT)) begin
         eff_max = ID_W'(ID_LIMIT);
      end else begin
         eff_max = max_index_ff;
      end
   end

   // A cursor left outside 1..max by a lowered maximum restarts at 1.
   assign req_start  = (cursor_ff == '0 || cursor_ff > eff_max) ? ID_W'(1) : cursor_ff;
   assign req_rel_ok = (req_release_id != '0) && (req_release_id <= eff_max);

   assign start_word = start_ff[BIT_W +: AW];
   assign last_word  = m_ff[BIT_W +: AW];
   assign next_word  = (issue_word_ff == last_word) ? '0 : issue_word_ff + AW'(1);

   // Words never written since reset read as all free.
   assign scan_data = row_valid_ff[ev_word_ff] ? ram_rd_data : '0;

   rria_word_pick u_pick (
      .word_data (scan_data),
      .word_num  (WN_W'(ev_word_ff)),
      .phase     (ev_phase_ff),
      .start_bit (start_ff[BIT_W-1:0]),
      .max_id    (m_ff),
      .pick      (pick)
   );

   assign found_id  = {WN_W'(ev_word_ff), pick.bit_idx};
   assign found_bit = WORD_W'(1) << pick.bit_idx;

   assign rel_ok   = (rid_ff != '0) && (rid_ff <= m_ff);
   assign rel_word = rid_ff[BIT_W +: AW];
   assign rel_bit  = WORD_W'(1) << rid_ff[BIT_W-1:0];
   assign rel_hit  = rel_ok && row_valid_ff[rel_word] && ((ram_rd_data & rel_bit) != '0);

   assign ram_wr_en = (state_ff == ST_FIN) && out_free && pend_wr_ff;

   always_comb begin
      state_in       = state_ff;
      max_index_in   = max_index_ff;
      cursor_in      = cursor_ff;
      count_in       = count_ff;
      row_valid_in   = row_valid_ff;
      m_in           = m_ff;
      start_in       = start_ff;
      rid_in         = rid_ff;
      issue_on_in    = issue_on_ff;
      issue_word_in  = issue_word_ff;
      issue_phase_in = issue_phase_ff;
      ev_valid_in    = 1'b0;
      ev_word_in     = ev_word_ff;
      ev_phase_in    = ev_phase_ff;
      pend_wr_in     = pend_wr_ff;
      pend_addr_in   = pend_addr_ff;
      pend_data_in   = pend_data_ff;
      pend_grant_in  = pend_grant_ff;
      pend_count_in  = pend_count_ff;
      pend_cursor_in = pend_cursor_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_grant_in   = rsp_grant_ff;
      rsp_count_in   = rsp_count_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;

      if (csr_write && csr_paddr == rria_pkg::MAX_INDEX_ADDR) begin
         max_index_in = csr_pwdata[ID_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               m_in     = eff_max;
               start_in = req_start;
               rid_in   = req_release_id;
               if (req_type == rria_pkg::REQ_RELEASE) begin
                  // Fetch the word holding the identifier to release.
                  ram_rd_en   = req_rel_ok;
                  ram_rd_addr = req_release_id[BIT_W +: AW];
                  state_in    = ST_REL;
               end else begin
                  issue_on_in    = 1'b1;
                  issue_word_in  = req_start[BIT_W +: AW];
                  issue_phase_in = rria_pkg::PH_FIRST;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // One word is read per cycle while the previously read word
            // is searched. The search wraps through word 0 and finishes on
            // the low bits of the starting word.
            if (issue_on_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = issue_word_ff;
               ev_valid_in = 1'b1;
               ev_word_in  = issue_word_ff;
               ev_phase_in = issue_phase_ff;
               if (issue_phase_ff == rria_pkg::PH_FINAL) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_word_in  = next_word;
                  issue_phase_in = (next_word == start_word) ? rria_pkg::PH_FINAL
                                                             : rria_pkg::PH_MID;
               end
            end
            if (ev_valid_ff) begin
               if (pick.found) begin
                  pend_wr_in     = 1'b1;
                  pend_addr_in   = ev_word_ff;
                  pend_data_in   = scan_data | found_bit;
                  pend_grant_in  = found_id;
                  pend_count_in  = count_ff + ID_W'(1);
                  pend_cursor_in = rria_pkg::advance(found_id, m_ff);
                  issue_on_in    = 1'b0;
                  ev_valid_in    = 1'b0;
                  state_in       = ST_FIN;
               end else if (ev_phase_ff == rria_pkg::PH_FINAL) begin
                  // Every identifier is taken: the cursor still moves on.
                  pend_wr_in     = 1'b0;
                  pend_grant_in  = '0;
                  pend_count_in  = count_ff;
                  pend_cursor_in = rria_pkg::advance(start_ff, m_ff);
                  issue_on_in    = 1'b0;
                  ev_valid_in    = 1'b0;
                  state_in       = ST_FIN;
               end
            end
         end
         ST_REL: begin
            // A release of an identifier out of range or not in use changes
            // nothing.
            pend_wr_in     = rel_hit;
            pend_addr_in   = rel_word;
            pend_data_in   = ram_rd_data & ~rel_bit;
            pend_grant_in  = '0;
            pend_count_in  = (rel_hit && count_ff != '0) ? count_ff - ID_W'(1) : count_ff;
            pend_cursor_in = cursor_ff;
            state_in       = ST_FIN;
         end
         ST_FIN: begin
            // The map, cursor and count are committed together with loading
            // the result, so the next request sees the updated state.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_grant_in = pend_grant_ff;
               rsp_count_in = pend_count_ff;
               count_in     = pend_count_ff;
               cursor_in    = pend_cursor_ff;
               if (pend_wr_ff) begin
                  row_valid_in[pend_addr_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_index_ff <= rria_pkg::MAX_INDEX_RESET;
         cursor_ff    <= ID_W'(1);
         count_ff     <= '0;
         row_valid_ff <= '0;
         issue_on_ff  <= 1'b0;
         ev_valid_ff  <= 1'b0;
         pend_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_index_ff <= max_index_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         row_valid_ff <= row_valid_in;
         issue_on_ff  <= issue_on_in;
         ev_valid_ff  <= ev_valid_in;
         pend_wr_ff   <= pend_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff           <= m_in;
      start_ff       <= start_in;
      rid_ff         <= rid_in;
      issue_word_ff  <= issue_word_in;
      issue_phase_ff <= issue_phase_in;
      ev_word_ff     <= ev_word_in;
      ev_phase_ff    <= ev_phase_in;
      pend_addr_ff   <= pend_addr_in;
      pend_data_ff   <= pend_data_in;
      pend_grant_ff  <= pend_grant_in;
      pend_count_ff  <= pend_count_in;
      pend_cursor_ff <= pend_cursor_in;
      rsp_grant_ff   <= rsp_grant_in;
      rsp_count_ff   <= rsp_count_in;
   end

   rria_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pend_addr_ff),
      .wr_data (pend_data_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_grant_ff;
   assign rsp_used_count = rsp_count_ff;

`ifndef SYNTH
   // The count of identifiers in use only ever moves by one per request.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
      (count_ff == $past(count_ff) + ID_W'(1) || count_ff == $past(count_ff) - ID_W'(1)))
      else $error("used count moved by more than one");

   // A granted identifier is counted in the same beat that carries it out.
   a_grant_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free && pend_grant_ff != '0) |=>
      (count_ff == $past(count_ff) + ID_W'(1) && rsp_used_count == count_ff))
      else $error("grant not reflected in used count");

   // Scan results are only evaluated while an allocation is searching.
   a_scan_owned: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff |-> (state_ff == ST_SCAN && !ram_wr_en))
      else $error("scan data outside an allocation");
`endif

endmodule

/* design/rria_ram.sv */
module rria_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 9
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rria_word_pick.sv */
module rria_word_pick (
   input  logic [rria_pkg::WORD_W-1:0] word_data,
   input  logic [rria_pkg::WN_W-1:0]   word_num,
   input  rria_pkg::phase_type         phase,
   input  logic [rria_pkg::BIT_W-1:0]  start_bit,
   input  logic [rria_pkg::ID_W-1:0]   max_id,
   output rria_pkg::pick_type          pick
);

   logic [rria_pkg::WORD_W-1:0] free_mask;

   // An identifier is a candidate when it is free, lies in 1..max_id and
   // belongs to the part of the word that this read is meant to cover.
   always_comb begin
      logic [rria_pkg::ID_W-1:0]  id;
      logic [rria_pkg::BIT_W-1:0] b;
      logic                       part_ok;
      for (int i = 0; i < rria_pkg::WORD_W; i++) begin
         b  = rria_pkg::BIT_W'(i);
         id = {word_num, b};
         case (phase)
            rria_pkg::PH_FIRST: part_ok = (b >= start_bit);
            rria_pkg::PH_FINAL: part_ok = (b < start_bit);
            default:            part_ok = 1'b1;
         endcase
         free_mask[i] = !word_data[i] && (id != '0) && (id <= max_id) && part_ok;
      end
   end

   always_comb begin
      pick.found   = 1'b0;
      pick.bit_idx = '0;
      for (int i = rria_pkg::WORD_W - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            pick.found   = 1'b1;
            pick.bit_idx = rria_pkg::BIT_W'(i);
         end
      end
   end

endmodule
